// File: design/text_console_writer_defines.svh
// assertion macros shared by the console checker
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NOW(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (conseq)) \
        else $error("console check failed: same-cycle rule");

// next-cycle implication, disabled while reset is asserted
`define TCW_ASSERT_NEXT(label, clk, rst_n, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (conseq)) \
        else $error("console check failed: next-cycle rule");

`endif

// File: design/tcw_pkg.sv
// shared constants, codes and beat types of the text console writer
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_WIDTH  = 8;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    // field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int IDX_W  = 11;
    localparam int SRC_W  = IDX_W + 1;
    localparam int CELL_W = 16;

    localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0700;
    localparam logic [7:0]        ATTR_RESET = 8'h07;

    // item kinds
    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_SCROLL = 2'd2;

    // control characters
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_CR  = 8'd13;

    // register byte addresses
    localparam logic [1:0] ADDR_TEXT_ATTR = 2'd0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PUT,
        ST_READ,
        ST_SCROLL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       character;
        logic [IDX_W-1:0] cell_index;
        logic [4:0]       scroll_lines;
    } t_item;

    typedef struct packed {
        logic [7:0]       cell_char;
        logic [7:0]       cell_attr;
        logic [COL_W-1:0] cursor_col;
        logic [ROW_W-1:0] cursor_row;
    } t_result;

endpackage

`default_nettype wire

// File: design/tcw_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/text_console_writer.sv
// text console writer: cell store, cursor and scroll sequencer
//
//  channel   | direction | handshake                  | beat
//  ----------+-----------+----------------------------+----------------------------
//  item      | in        | start high while busy low  | kind, character, index, lines
//  result    | out       | o_valid, one cycle         | cell char/attr, cursor
//  config    | in        | apb write, pready tied one | text attribute
//
// put and read pass through their own state and then the done state that strobes the result;
//   unused kinds and a zero scroll go straight to the done state
// a scroll of n > 0 lines copies the whole 2000-cell ram, one cell a cycle; a put that moves
//   past the last row adds that one-line scroll; after reset a clearing pass writes every cell blank
// the result receiver cannot stall; busy stays high until the strobe cycle ends
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tcw_pkg::t_item  i_item,
    output logic                 o_valid,
    output tcw_pkg::t_result     o_result,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [1:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    import tcw_pkg::*;

    t_state           r_state, n_state;
    t_item            r_item;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_line, n_line;
    logic [7:0]       r_attr;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [SRC_W-1:0] r_shift, n_shift;
    logic             r_wv, n_wv;
    logic [IDX_W-1:0] r_widx, n_widx;
    logic             r_wcopy, n_wcopy;

    logic             accept;
    logic             idx_last;
    logic             cfg_write;

    logic [COL_W-1:0] tab_col;
    logic [ROW_W:0]   line_inc;
    logic [COL_W-1:0] put_col;
    logic [ROW_W:0]   put_line;
    logic             put_write;
    logic             put_scroll;
    logic [IDX_W-1:0] put_pos;

    logic [SRC_W-1:0] start_shift;
    logic [ROW_W-1:0] start_line;
    logic [SRC_W-1:0] src;
    logic             src_ok;
    logic             rd_hit;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    assign accept   = start && (r_state == ST_IDLE);
    assign idx_last = (r_idx == IDX_W'(CELL_COUNT - 1));

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr == ADDR_TEXT_ATTR);
    assign prdata    = (paddr == ADDR_TEXT_ATTR) ? {24'd0, r_attr} : 32'd0;

    // put: cursor motion and cell write for one character
    assign tab_col  = r_col + COL_W'(TAB_WIDTH) - (r_col & COL_W'(TAB_WIDTH - 1));
    assign line_inc = {1'b0, r_line} + (ROW_W + 1)'(1);
    assign put_pos  = IDX_W'(r_line) * IDX_W'(COLUMNS) + IDX_W'(r_col);

    always_comb begin
        put_col   = r_col;
        put_line  = {1'b0, r_line};
        put_write = 1'b0;
        case (r_item.character)
            CH_LF: begin
                put_col  = '0;
                put_line = line_inc;
            end
            CH_TAB: begin
                if (tab_col >= COL_W'(COLUMNS)) begin
                    put_col  = '0;
                    put_line = line_inc;
                end else begin
                    put_col = tab_col;
                end
            end
            CH_CR: begin
                put_col = '0;
            end
            default: begin
                put_write = 1'b1;
                if (r_col + COL_W'(1) >= COL_W'(COLUMNS)) begin
                    put_col  = '0;
                    put_line = line_inc;
                end else begin
                    put_col = r_col + COL_W'(1);
                end
            end
        endcase
    end

    assign put_scroll = (put_line > (ROW_W + 1)'(ROWS - 1));

    // scroll setup: cell offset and saturated cursor line
    always_comb begin
        if (i_item.scroll_lines >= 5'(ROWS)) begin
            start_shift = SRC_W'(CELL_COUNT);
        end else begin
            start_shift = SRC_W'(i_item.scroll_lines) * SRC_W'(COLUMNS);
        end
        if (r_line > i_item.scroll_lines) begin
            start_line = r_line - i_item.scroll_lines;
        end else begin
            start_line = '0;
        end
    end

    // shared adder: source cell of the current copy step
    assign src    = SRC_W'(r_idx) + r_shift;
    assign src_ok = (src < SRC_W'(CELL_COUNT));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (idx_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_item.kind)
                        KIND_PUT:    n_state = ST_PUT;
                        KIND_READ:   n_state = ST_READ;
                        KIND_SCROLL: n_state = (i_item.scroll_lines == 5'd0) ? ST_DONE
                                                                              : ST_SCROLL;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_PUT:    n_state = put_scroll ? ST_SCROLL : ST_DONE;
            ST_READ:   n_state = ST_DONE;
            ST_SCROLL: n_state = idx_last ? ST_DONE : ST_SCROLL;
            ST_DONE:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath next values
    always_comb begin
        n_col   = r_col;
        n_line  = r_line;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_wv    = 1'b0;
        n_widx  = r_widx;
        n_wcopy = r_wcopy;
        case (r_state)
            ST_CLEAR: begin
                n_idx = r_idx + IDX_W'(1);
            end
            ST_IDLE: begin
                if (accept && (i_item.kind == KIND_SCROLL)) begin
                    n_idx   = '0;
                    n_shift = start_shift;
                    n_line  = start_line;
                end
            end
            ST_PUT: begin
                n_col = put_col;
                if (put_scroll) begin
                    n_line  = ROW_W'(ROWS - 1);
                    n_shift = SRC_W'(COLUMNS);
                    n_idx   = '0;
                end else begin
                    n_line = put_line[ROW_W-1:0];
                end
            end
            ST_SCROLL: begin
                n_idx   = r_idx + IDX_W'(1);
                n_wv    = 1'b1;
                n_widx  = r_idx;
                n_wcopy = src_ok;
            end
            default: begin
            end
        endcase
    end

    // outputs and ram control
    always_comb begin
        busy      = (r_state != ST_IDLE);
        o_valid   = (r_state == ST_DONE);
        ram_we    = 1'b0;
        ram_waddr = r_widx;
        ram_wdata = r_wcopy ? ram_rdata : BLANK_CELL;
        ram_re    = 1'b0;
        ram_raddr = src[IDX_W-1:0];
        unique case (r_state)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = BLANK_CELL;
            end
            ST_PUT: begin
                ram_we    = put_write;
                ram_waddr = put_pos;
                ram_wdata = {r_attr, r_item.character};
            end
            ST_READ: begin
                ram_re    = (r_item.cell_index < IDX_W'(CELL_COUNT));
                ram_raddr = r_item.cell_index;
            end
            ST_SCROLL: begin
                ram_we = r_wv;
                ram_re = src_ok;
            end
            ST_DONE: begin
                ram_we = r_wv;
            end
            default: begin
            end
        endcase
    end

    // result beat
    assign rd_hit = (r_item.kind == KIND_READ) && (r_item.cell_index < IDX_W'(CELL_COUNT));
    assign o_result.cell_char  = rd_hit ? ram_rdata[7:0]  : 8'd0;
    assign o_result.cell_attr  = rd_hit ? ram_rdata[15:8] : 8'd0;
    assign o_result.cursor_col = r_col;
    assign o_result.cursor_row = r_line;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_col   <= '0;
            r_line  <= '0;
            r_attr  <= ATTR_RESET;
            r_wv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_col   <= n_col;
            r_line  <= n_line;
            r_wv    <= n_wv;
            if (cfg_write) begin
                r_attr <= pwdata[7:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_shift <= n_shift;
        r_widx  <= n_widx;
        r_wcopy <= n_wcopy;
    end

    // cell store
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

// File: design/tcw_checker.sv
// port-level checks of the text console writer and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_writer_defines.svh"

module tcw_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             o_valid,
    input wire tcw_pkg::t_result o_result
);

    import tcw_pkg::*;

    // one result per item, never two strobes back to back
    `TCW_ASSERT_NEXT(a_single_strobe, i_clk, i_rst_n, o_valid, !o_valid)

    // an accepted item holds the block busy
    `TCW_ASSERT_NEXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy)

    // the strobe falls inside the busy window and ends it
    `TCW_ASSERT_NOW(a_valid_while_busy, i_clk, i_rst_n, o_valid, busy)
    `TCW_ASSERT_NEXT(a_idle_after_valid, i_clk, i_rst_n, o_valid, !busy)

    // reported cursor stays on the screen
    `TCW_ASSERT_NOW(a_cursor_on_screen, i_clk, i_rst_n, o_valid,
        (o_result.cursor_row <= ROW_W'(ROWS - 1)) && (o_result.cursor_col <= COL_W'(COLUMNS - 1)))

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// File: verif/tb.sv
// self-checking testbench of the text console writer: item stream, apb attribute, cursor
`timescale 1ns / 1ps

module tb;
    import tcw_pkg::*;

    localparam logic [1:0] KIND_UNUSED    = 2'd3;
    localparam int         RESULT_LATENCY = 3;
    localparam int         DRAIN_LIMIT    = 10000;
    localparam int         RANDOM_ITEMS   = 1400;
    localparam int         PHASE_ITEMS    = 350;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    t_item         i_item  = '0;
    logic          o_valid;
    t_result       o_result;
    logic          psel    = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite  = 1'b0;
    logic [1:0]    paddr   = '0;
    logic [31:0]   pwdata  = '0;
    logic [31:0]   prdata;
    logic          pready;

    // shadow copy of the console: cells, cursor and attribute register
    logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
    int unsigned       shadow_col;
    int unsigned       shadow_line;
    logic [7:0]        shadow_attr;

    // predicted result beats, oldest first
    t_result pending_readouts [$];

    int error_count  = 0;
    int counted_items = 0;
    bit sender_idles = 1'b1;

    text_console_writer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $time, what);
        error_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
        end
    endtask

    function automatic void reset_shadow();
        foreach (shadow_cells[i]) shadow_cells[i] = BLANK_CELL;
        shadow_col  = 0;
        shadow_line = 0;
        shadow_attr = ATTR_RESET;
    endfunction

    // scroll up, blank rows enter at the bottom, cursor row saturates at zero
    function automatic void shadow_scroll(input int unsigned lines);
        int unsigned shift;
        if (lines == 0) return;
        if (lines >= ROWS) begin
            foreach (shadow_cells[i]) shadow_cells[i] = BLANK_CELL;
            shadow_line = 0;
            return;
        end
        shift = lines * COLUMNS;
        for (int unsigned i = 0; i < CELL_COUNT; i++) begin
            if (i + shift < CELL_COUNT) shadow_cells[i] = shadow_cells[i + shift];
            else shadow_cells[i] = BLANK_CELL;
        end
        shadow_line = (shadow_line > lines) ? shadow_line - lines : 0;
    endfunction

    // one character: controls only move the cursor, others print and advance
    function automatic void shadow_put(input logic [7:0] ch);
        case (ch)
            CH_LF: begin
                shadow_col = 0;
                shadow_line++;
            end
            CH_TAB: begin
                shadow_col = shadow_col + TAB_WIDTH - (shadow_col % TAB_WIDTH);
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_line++;
                end
            end
            CH_CR: begin
                shadow_col = 0;
            end
            default: begin
                shadow_cells[shadow_line * COLUMNS + shadow_col] = {shadow_attr, ch};
                shadow_col++;
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_line++;
                end
            end
        endcase
        if (shadow_line > ROWS - 1) shadow_scroll(shadow_line - (ROWS - 1));
    endfunction

    function automatic t_result predict_readout(input t_item it);
        t_result r;
        r = '0;
        case (it.kind)
            KIND_PUT: begin
                shadow_put(it.character);
            end
            KIND_READ: begin
                if (it.cell_index < CELL_COUNT) begin
                    {r.cell_attr, r.cell_char} = shadow_cells[it.cell_index];
                end
            end
            KIND_SCROLL: begin
                shadow_scroll(it.scroll_lines);
            end
            default: ;
        endcase
        r.cursor_col = COL_W'(shadow_col);
        r.cursor_row = ROW_W'(shadow_line);
        return r;
    endfunction

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_readouts.size() == 0) begin
                report_mismatch($sformatf("result beat %h with none expected", o_result));
            end else begin
                want = pending_readouts.pop_front();
                check_field("cell_char", o_result.cell_char, want.cell_char);
                check_field("cell_attr", o_result.cell_attr, want.cell_attr);
                check_field("cursor_col", o_result.cursor_col, want.cursor_col);
                check_field("cursor_row", o_result.cursor_row, want.cursor_row);
            end
        end
    end

    // start stays high between back-to-back beats, dropped only for a gap
    task automatic send_item(input t_item it);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 9) : 0;
        if (gap != 0) begin
            if (start) start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_readouts.push_back(predict_readout(it));
        if (it.kind != KIND_UNUSED) counted_items++;
    endtask

    task automatic wait_all_results();
        if (start) start <= 1'b0;
        while (pending_readouts.size() != 0) @(posedge i_clk);
    endtask

    // apb write of the attribute register, then read it back
    task automatic write_text_attr(input logic [7:0] value);
        wait_all_results();
        while (busy) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TEXT_ATTR;
        pwdata  <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        shadow_attr = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[7:0] != value) begin
            report_mismatch($sformatf("text_attr read %h want %h", prdata[7:0], value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // unused fields carry random bits so the block must ignore them
    function automatic t_item random_item();
        t_item it;
        it.kind         = 2'($urandom_range(0, 3));
        it.character    = 8'($urandom_range(0, 255));
        it.cell_index   = IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
        it.scroll_lines = 5'($urandom_range(0, 31));
        return it;
    endfunction

    task automatic put_char(input logic [7:0] ch);
        t_item it;
        it           = random_item();
        it.kind      = KIND_PUT;
        it.character = ch;
        send_item(it);
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] idx);
        t_item it;
        it            = random_item();
        it.kind       = KIND_READ;
        it.cell_index = idx;
        send_item(it);
    endtask

    task automatic scroll_up(input logic [4:0] lines);
        t_item it;
        it              = random_item();
        it.kind         = KIND_SCROLL;
        it.scroll_lines = lines;
        send_item(it);
    endtask

    task automatic send_unused();
        t_item it;
        it      = random_item();
        it.kind = KIND_UNUSED;
        send_item(it);
    endtask

    // mostly plain text, sometimes any code at all
    function automatic logic [7:0] text_char();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h20, 8'h7E));
    endfunction

    // reads favor the cursor row and rows above it, where text was printed
    function automatic logic [IDX_W-1:0] pick_cell();
        case ($urandom_range(0, 4))
            0, 1: return IDX_W'(shadow_line * COLUMNS + $urandom_range(0, COLUMNS - 1));
            2: return IDX_W'($urandom_range(0, shadow_line) * COLUMNS
                             + $urandom_range(0, COLUMNS - 1));
            3: return IDX_W'($urandom_range(0, CELL_COUNT - 1));
            default: return IDX_W'($urandom_range(0, 2 ** IDX_W - 1));
        endcase
    endfunction

    // blank screen after the clearing pass, reads past the store return zero
    task automatic test_reset_contents();
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(CELL_COUNT - 1));
        read_cell(IDX_W'(CELL_COUNT));
        read_cell(IDX_W'(2 ** IDX_W - 1));
    endtask

    // printing with both attribute extremes and character extremes
    task automatic test_printing();
        write_text_attr(8'hFF);
        put_char(8'h00);
        put_char(8'hFF);
        write_text_attr(8'h00);
        put_char(8'h41);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        read_cell(IDX_W'(2));
        read_cell(IDX_W'(3));
    endtask

    task automatic test_control_characters();
        put_char(CH_TAB);
        put_char(CH_CR);
        put_char(CH_TAB);
        put_char(CH_LF);
        put_char(CH_TAB);
    endtask

    task automatic test_unused_kind();
        send_unused();
        send_unused();
    endtask

    // zero count, one line, a full clear and the largest count
    task automatic test_scroll_counts();
        scroll_up(5'd0);
        scroll_up(5'd1);
        read_cell(IDX_W'((ROWS - 1) * COLUMNS));
        put_char(CH_LF);
        put_char(8'h5A);
        scroll_up(5'd31);
        read_cell(IDX_W'(COLUMNS));
        scroll_up(5'd25);
    endtask

    // text lines, wrapping runs, tabs, reads, scrolls and noise
    task automatic test_random_traffic();
        int unsigned pick;
        int          phase_mark;
        counted_items = 0;
        phase_mark    = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if (counted_items >= phase_mark) begin
                write_text_attr(8'($urandom_range(0, 255)));
                phase_mark += PHASE_ITEMS;
            end else if ($urandom_range(0, 39) == 0) begin
                wait_all_results();
            end
            sender_idles = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                repeat ($urandom_range(1, 30)) put_char(text_char());
                case ($urandom_range(0, 3))
                    0: begin
                        put_char(CH_CR);
                    end
                    1: begin
                        put_char(CH_CR);
                        put_char(CH_LF);
                    end
                    default: begin
                        put_char(CH_LF);
                    end
                endcase
            end else if (pick < 40) begin
                repeat ($urandom_range(60, 120)) begin
                    put_char(($urandom_range(0, 15) == 0) ? CH_TAB : text_char());
                end
            end else if (pick < 48) begin
                repeat ($urandom_range(1, 12)) put_char(CH_TAB);
            end else if (pick < 70) begin
                repeat ($urandom_range(1, 8)) read_cell(pick_cell());
            end else if (pick < 75) begin
                if ($urandom_range(0, 3) == 0) scroll_up(5'($urandom_range(0, 31)));
                else scroll_up(5'($urandom_range(0, 3)));
            end else if (pick < 80) begin
                repeat ($urandom_range(1, 4)) send_item(random_item());
            end else if (pick < 84) begin
                repeat ($urandom_range(1, 3)) send_unused();
            end else if (pick < 90) begin
                repeat ($urandom_range(1, 6)) put_char(CH_LF);
            end else begin
                put_char(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // stimulus sequence and end of run
    initial begin
        int unsigned waited;
        reset_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_contents();
        test_printing();
        test_control_characters();
        test_unused_kind();
        test_scroll_counts();
        test_random_traffic();

        if (start) start <= 1'b0;
        waited = 0;
        while (pending_readouts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_readouts.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_readouts.size()));
        end
        repeat (RESULT_LATENCY + 4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // run limit, far above the slowest correct run
    initial begin
        #250_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: text_console_writer.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ram.sv
design/text_console_writer.sv
design/tcw_checker.sv
verif/tb.sv
